// File: rtl/zzr_pkg.sv
// ----------------------------------------------------------------------------
// zzr_pkg
// Shared types and constants for the zigzag matrix reorder unit: request
// function codes, register indexes, fixed port widths and the command
// bundle passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package zzr_pkg;

   // Fixed widths of the request, response and register ports.
   localparam int DATA_IN_W  = 32;
   localparam int DATA_OUT_W = 32;
   localparam int ROW_OUT_W  = 4;
   localparam int COL_OUT_W  = 4;
   localparam int CSR_DATA_W = 5;
   localparam int CSR_INDEX_W = 1;

   // Matrix geometry after reset, before clamping to the build limits.
   localparam int RESET_DIM = 8;

   // Request function codes.
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_ROWS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_COLS = 1'b1;

   typedef enum logic {
      ST_EMPTY,
      ST_FULL
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic read;
   } cmd_type;

endpackage

// File: rtl/zzr_ctrl.sv
// ----------------------------------------------------------------------------
// zzr_ctrl
// Handshake controller. Tracks whether the response register holds a result,
// decides when a request is taken and tells the datapath to load or read.
// ----------------------------------------------------------------------------
module zzr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_func,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output zzr_pkg::cmd_type cmd
);

   zzr_pkg::ctrl_state_type state_ff;
   zzr_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= zzr_pkg::ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         zzr_pkg::ST_EMPTY: begin
            if (req_valid) begin
               if (req_func == zzr_pkg::FUNC_READ) begin
                  cmd.read = 1'b1;
                  state_in = zzr_pkg::ST_FULL;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         zzr_pkg::ST_FULL: begin
            rsp_valid = 1'b1;
            req_stall = rsp_stall;
            // The response register frees up at this edge, so a new request
            // can be taken and may refill it right away.
            if (!rsp_stall) begin
               state_in = zzr_pkg::ST_EMPTY;
               if (req_valid) begin
                  if (req_func == zzr_pkg::FUNC_READ) begin
                     cmd.read = 1'b1;
                     state_in = zzr_pkg::ST_FULL;
                  end else begin
                     cmd.load = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = zzr_pkg::ST_EMPTY;
         end
      endcase
   end

endmodule

// File: rtl/zzr_datapath.sv
// ----------------------------------------------------------------------------
// zzr_datapath
// Geometry registers, load pointer, zigzag cursor, element store and the
// response register. Acts on the load and read commands of the controller.
// ----------------------------------------------------------------------------
module zzr_datapath #(
   parameter int MAX_ROWS   = 16,
   parameter int MAX_COLS   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  zzr_pkg::cmd_type                      cmd,
   input  logic [zzr_pkg::DATA_IN_W-1:0]         req_value,
   input  logic                                  csr_wr_en,
   input  logic [zzr_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [zzr_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output logic [zzr_pkg::DATA_OUT_W-1:0]        rsp_data,
   output logic [zzr_pkg::ROW_OUT_W-1:0]         rsp_row,
   output logic [zzr_pkg::COL_OUT_W-1:0]         rsp_col,
   output logic                                  rsp_last,
   output logic                                  rsp_status
);

   localparam int DEPTH     = MAX_ROWS * MAX_COLS;
   localparam int STORE_W   = (DATA_WIDTH < zzr_pkg::DATA_IN_W) ? DATA_WIDTH
                                                                : zzr_pkg::DATA_IN_W;
   localparam int ROW_IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_NUM_W = $clog2(MAX_ROWS + 1);
   localparam int COL_NUM_W = $clog2(MAX_COLS + 1);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ROWS_RST  = (zzr_pkg::RESET_DIM > MAX_ROWS) ? MAX_ROWS
                                                              : zzr_pkg::RESET_DIM;
   localparam int COLS_RST  = (zzr_pkg::RESET_DIM > MAX_COLS) ? MAX_COLS
                                                              : zzr_pkg::RESET_DIM;

   logic [ROW_NUM_W-1:0] rows_ff, rows_in;
   logic [COL_NUM_W-1:0] cols_ff, cols_in;
   logic [CNT_W-1:0]     load_count_ff, load_count_in;
   logic [CNT_W-1:0]     scan_count_ff, scan_count_in;
   logic [ROW_IDX_W-1:0] scan_row_ff, scan_row_in;
   logic [COL_IDX_W-1:0] scan_col_ff, scan_col_in;
   logic                 going_up_ff, going_up_in;

   logic [zzr_pkg::DATA_OUT_W-1:0] rsp_data_ff;
   logic [zzr_pkg::ROW_OUT_W-1:0]  rsp_row_ff;
   logic [zzr_pkg::COL_OUT_W-1:0]  rsp_col_ff;
   logic                           rsp_last_ff;
   logic                           rsp_status_ff;

   logic [STORE_W-1:0] store_mem [DEPTH];

   logic [CNT_W-1:0]  total;
   logic              loaded;
   logic              last;
   logic [CNT_W-1:0]  wr_idx;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   // Register values of zero act as one and values above the build limit
   // act as the limit.
   function automatic logic [ROW_NUM_W-1:0] clamp_rows(
      input logic [zzr_pkg::CSR_DATA_W-1:0] v
   );
      logic [ROW_NUM_W-1:0] r;
      if (v == '0) begin
         r = ROW_NUM_W'(1);
      end else if (int'(v) > MAX_ROWS) begin
         r = ROW_NUM_W'(MAX_ROWS);
      end else begin
         r = ROW_NUM_W'(v);
      end
      return r;
   endfunction

   function automatic logic [COL_NUM_W-1:0] clamp_cols(
      input logic [zzr_pkg::CSR_DATA_W-1:0] v
   );
      logic [COL_NUM_W-1:0] c;
      if (v == '0) begin
         c = COL_NUM_W'(1);
      end else if (int'(v) > MAX_COLS) begin
         c = COL_NUM_W'(MAX_COLS);
      end else begin
         c = COL_NUM_W'(v);
      end
      return c;
   endfunction

   assign total   = CNT_W'(rows_ff) * CNT_W'(cols_ff);
   assign loaded  = (load_count_ff >= total);
   assign last    = ((scan_count_ff + CNT_W'(1)) >= total);
   assign wr_idx  = loaded ? '0 : load_count_ff;
   assign wr_addr = ADDR_W'(wr_idx);
   assign rd_addr = ADDR_W'((CNT_W'(scan_row_ff) * CNT_W'(cols_ff))
                            + CNT_W'(scan_col_ff));

   always_comb begin
      rows_in       = rows_ff;
      cols_in       = cols_ff;
      load_count_in = load_count_ff;
      scan_count_in = scan_count_ff;
      scan_row_in   = scan_row_ff;
      scan_col_in   = scan_col_ff;
      going_up_in   = going_up_ff;

      if (csr_wr_en) begin
         case (csr_index)
            zzr_pkg::CSR_NUM_ROWS: rows_in = clamp_rows(csr_wdata);
            zzr_pkg::CSR_NUM_COLS: cols_in = clamp_cols(csr_wdata);
            default: ;
         endcase
         load_count_in = '0;
         scan_count_in = '0;
         scan_row_in   = '0;
         scan_col_in   = '0;
         going_up_in   = 1'b1;
      end else if (cmd.load) begin
         load_count_in = wr_idx + CNT_W'(1);
         // The first element of a matrix restarts the scan.
         if (wr_idx == '0) begin
            scan_count_in = '0;
            scan_row_in   = '0;
            scan_col_in   = '0;
            going_up_in   = 1'b1;
         end
      end else if (cmd.read && loaded) begin
         if (last) begin
            scan_count_in = '0;
            scan_row_in   = '0;
            scan_col_in   = '0;
            going_up_in   = 1'b1;
         end else begin
            scan_count_in = scan_count_ff + CNT_W'(1);
            if (going_up_ff) begin
               if ((COL_NUM_W'(scan_col_ff) + COL_NUM_W'(1)) >= cols_ff) begin
                  scan_row_in = scan_row_ff + ROW_IDX_W'(1);
                  going_up_in = 1'b0;
               end else if (scan_row_ff == '0) begin
                  scan_col_in = scan_col_ff + COL_IDX_W'(1);
                  going_up_in = 1'b0;
               end else begin
                  scan_row_in = scan_row_ff - ROW_IDX_W'(1);
                  scan_col_in = scan_col_ff + COL_IDX_W'(1);
               end
            end else begin
               if ((ROW_NUM_W'(scan_row_ff) + ROW_NUM_W'(1)) >= rows_ff) begin
                  scan_col_in = scan_col_ff + COL_IDX_W'(1);
                  going_up_in = 1'b1;
               end else if (scan_col_ff == '0) begin
                  scan_row_in = scan_row_ff + ROW_IDX_W'(1);
                  going_up_in = 1'b1;
               end else begin
                  scan_row_in = scan_row_ff + ROW_IDX_W'(1);
                  scan_col_in = scan_col_ff - COL_IDX_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff       <= ROW_NUM_W'(ROWS_RST);
         cols_ff       <= COL_NUM_W'(COLS_RST);
         load_count_ff <= '0;
         scan_count_ff <= '0;
         scan_row_ff   <= '0;
         scan_col_ff   <= '0;
         going_up_ff   <= 1'b1;
      end else begin
         rows_ff       <= rows_in;
         cols_ff       <= cols_in;
         load_count_ff <= load_count_in;
         scan_count_ff <= scan_count_in;
         scan_row_ff   <= scan_row_in;
         scan_col_ff   <= scan_col_in;
         going_up_ff   <= going_up_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         store_mem[wr_addr] <= req_value[STORE_W-1:0];
      end
   end

   // The store read lands directly in the response register.
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rsp_data_ff   <= loaded ? zzr_pkg::DATA_OUT_W'(store_mem[rd_addr]) : '0;
         rsp_row_ff    <= zzr_pkg::ROW_OUT_W'(scan_row_ff);
         rsp_col_ff    <= zzr_pkg::COL_OUT_W'(scan_col_ff);
         rsp_last_ff   <= last;
         rsp_status_ff <= !loaded;
      end
   end

   assign rsp_data   = rsp_data_ff;
   assign rsp_row    = rsp_row_ff;
   assign rsp_col    = rsp_col_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// File: rtl/zigzag_matrix_reorder_unit.sv
// ----------------------------------------------------------------------------
// zigzag_matrix_reorder_unit
// Loads a matrix in row-major order and returns its elements in zigzag order.
// ----------------------------------------------------------------------------
// Usage:
// A request with func load writes the next element in row-major order; after
// rows*cols elements the pointer wraps and the next load starts a new matrix
// and restarts the scan. A request with func read returns the element at the
// zigzag cursor with its row, column, last flag and status. Status is set and
// data is zero while the matrix is not completely loaded; the cursor then
// holds its place. The csr port sets the rows and columns in use and
// restarts both the load pointer and the scan.
// One request is taken per clock while req_stall is low; a read response
// appears in the response register the cycle after the request, which is
// the registered read port of the element store. Loads give no
// response. While a response waits under rsp_stall, req_stall is raised and
// no request is taken. Reset empties the response register, sets the
// geometry to 8 by 8 (clamped to the build limits) and restarts the load
// pointer and scan; the store itself is not cleared.
// ----------------------------------------------------------------------------
module zigzag_matrix_reorder_unit #(
   parameter int MAX_ROWS   = 16,
   parameter int MAX_COLS   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_func,
   input  logic signed [zzr_pkg::DATA_IN_W-1:0]  req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [zzr_pkg::DATA_OUT_W-1:0] rsp_data,
   output logic [zzr_pkg::ROW_OUT_W-1:0]         rsp_row,
   output logic [zzr_pkg::COL_OUT_W-1:0]         rsp_col,
   output logic                                  rsp_last,
   output logic                                  rsp_status,
   input  logic                                  csr_wr_en,
   input  logic [zzr_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [zzr_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   zzr_pkg::cmd_type cmd;

   zzr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   zzr_datapath #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_value  (req_value),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_data   (rsp_data),
      .rsp_row    (rsp_row),
      .rsp_col    (rsp_col),
      .rsp_last   (rsp_last),
      .rsp_status (rsp_status)
   );

   // Every accepted read produces a response in the next cycle.
   a_read_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_func == zzr_pkg::FUNC_READ) |=> rsp_valid)
      else $error("accepted read did not produce a response");

   // An accepted load never produces a response on its own.
   a_load_no_rsp : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_func == zzr_pkg::FUNC_LOAD
       && (!rsp_valid || !rsp_stall)) |=> !rsp_valid)
      else $error("accepted load produced a response");

   // A failed read carries zero data.
   a_status_zero_data : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_data == '0))
      else $error("response with status set carries nonzero data");

   // No request is taken while a response is held back.
   a_hold_blocks_req : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken while response register is held");

endmodule

// File: bench/zigzag_matrix_reorder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zigzag_matrix_reorder_unit_tb
// Loads matrices of many shapes into the reorder unit and reads them back.
// Every read response is checked field by field against a model of the
// zigzag scan that runs beside the block. A short fixed sequence covers the
// value extremes, clamped geometry, a read of a partly loaded matrix and
// pointer wrap. After it come random segments: mostly complete load-then-read
// passes, and some loose mixes of loads and reads. Both sides of the
// handshake idle in random bursts.
// ----------------------------------------------------------------------------
module zigzag_matrix_reorder_unit_tb;

   localparam int ITEM_TARGET = 1650;
   localparam int TAIL_ITEMS  = 150;
   localparam int LONG_HOLD   = 150;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DIM_LIMIT   = 16;
   localparam int STORE_SIZE  = 256;

   typedef struct packed {
      logic signed [zzr_pkg::DATA_OUT_W-1:0] data;
      logic [zzr_pkg::ROW_OUT_W-1:0]         row;
      logic [zzr_pkg::COL_OUT_W-1:0]         col;
      logic                                  last;
      logic                                  status;
   } zigzag_beat_type;

   typedef enum int {
      STEP_LOAD,
      STEP_READ,
      STEP_GEOM
   } step_kind_type;

   typedef struct {
      step_kind_type                        kind;
      logic signed [zzr_pkg::DATA_IN_W-1:0] value;
      logic [zzr_pkg::CSR_DATA_W-1:0]       rows;
      logic [zzr_pkg::CSR_DATA_W-1:0]       cols;
      bit                                   pinned;
      zigzag_beat_type                      want;
   } dir_step_type;

   localparam int DIR_LEN = 22;

   // Rows with a typed response are the ones that follow directly from reset,
   // a one-element matrix or a partly loaded matrix.
   dir_step_type dir_table [DIR_LEN] = '{
      '{STEP_READ, 32'sd0, 5'd0, 5'd0, 1'b1, '{32'sd0, 4'd0, 4'd0, 1'b0, 1'b1}},
      '{STEP_GEOM, 32'sd0, 5'd0, 5'd0, 1'b0, '0},
      '{STEP_READ, 32'sd0, 5'd0, 5'd0, 1'b1, '{32'sd0, 4'd0, 4'd0, 1'b1, 1'b1}},
      '{STEP_LOAD, 32'sh7FFFFFFF, 5'd0, 5'd0, 1'b0, '0},
      '{STEP_READ, 32'sd0, 5'd0, 5'd0, 1'b1,
        '{32'sh7FFFFFFF, 4'd0, 4'd0, 1'b1, 1'b0}},
      '{STEP_LOAD, 32'sh80000000, 5'd0, 5'd0, 1'b0, '0},
      '{STEP_READ, -32'sd1, 5'd0, 5'd0, 1'b1,
        '{32'sh80000000, 4'd0, 4'd0, 1'b1, 1'b0}},
      '{STEP_GEOM, 32'sd0, 5'd2, 5'd3, 1'b0, '0},
      '{STEP_LOAD, -32'sd1, 5'd0, 5'd0, 1'b0, '0},
      '{STEP_LOAD, 32'sd0, 5'd0, 5'd0, 1'b0, '0},
      '{STEP_LOAD, 32'sd1, 5'd0, 5'd0, 1'b0, '0},
      '{STEP_READ, 32'sd0, 5'd0, 5'd0, 1'b1, '{32'sd0, 4'd0, 4'd0, 1'b0, 1'b1}},
      '{STEP_LOAD, 32'sh55555555, 5'd0, 5'd0, 1'b0, '0},
      '{STEP_LOAD, 32'shAAAAAAAA, 5'd0, 5'd0, 1'b0, '0},
      '{STEP_LOAD, 32'sh12345678, 5'd0, 5'd0, 1'b0, '0},
      '{STEP_READ, 32'sd0, 5'd0, 5'd0, 1'b0, '0},
      '{STEP_READ, 32'sd0, 5'd0, 5'd0, 1'b0, '0},
      '{STEP_READ, 32'sd0, 5'd0, 5'd0, 1'b0, '0},
      '{STEP_READ, 32'sd0, 5'd0, 5'd0, 1'b0, '0},
      '{STEP_READ, 32'sd0, 5'd0, 5'd0, 1'b0, '0},
      '{STEP_READ, 32'sd0, 5'd0, 5'd0, 1'b0, '0},
      '{STEP_READ, 32'sd0, 5'd0, 5'd0, 1'b0, '0}
   };

   logic                                   clock;
   logic                                   reset;
   logic                                   req_valid;
   logic                                   req_stall;
   logic                                   req_func;
   logic signed [zzr_pkg::DATA_IN_W-1:0]   req_value;
   logic                                   rsp_valid;
   logic                                   rsp_stall;
   logic signed [zzr_pkg::DATA_OUT_W-1:0]  rsp_data;
   logic [zzr_pkg::ROW_OUT_W-1:0]          rsp_row;
   logic [zzr_pkg::COL_OUT_W-1:0]          rsp_col;
   logic                                   rsp_last;
   logic                                   rsp_status;
   logic                                   csr_wr_en;
   logic [zzr_pkg::CSR_INDEX_W-1:0]        csr_index;
   logic [zzr_pkg::CSR_DATA_W-1:0]         csr_wdata;

   // Model of the block: element store, load pointer, scan cursor, geometry.
   logic signed [zzr_pkg::DATA_IN_W-1:0]   elem_mem [STORE_SIZE];
   int                                     fill_count;
   int                                     cur_row;
   int                                     cur_col;
   bit                                     cur_up;
   int                                     scan_index;
   logic [zzr_pkg::CSR_DATA_W-1:0]         cfg_rows;
   logic [zzr_pkg::CSR_DATA_W-1:0]         cfg_cols;

   zigzag_beat_type                        pending_beats [$];
   int                                     error_count = 0;
   int                                     cycle_count = 0;
   int                                     items_sent = 0;
   int                                     idle_pct = 0;
   bit                                     hold_off_req = 1'b0;
   bit                                     pin_valid = 1'b0;
   zigzag_beat_type                        pin_beat = '0;

   zigzag_matrix_reorder_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_func   (req_func),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .rsp_row    (rsp_row),
      .rsp_col    (rsp_col),
      .rsp_last   (rsp_last),
      .rsp_status (rsp_status),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int dim_in_use(input logic [zzr_pkg::CSR_DATA_W-1:0] v);
      if (v == 0) return 1;
      if (v > DIM_LIMIT) return DIM_LIMIT;
      return int'(v);
   endfunction

   task automatic restart_scan();
      cur_row = 0;
      cur_col = 0;
      cur_up = 1'b1;
      scan_index = 0;
   endtask

   task automatic predict_request(input logic func,
                                  input logic signed [zzr_pkg::DATA_IN_W-1:0] value,
                                  output bit has_beat, output zigzag_beat_type beat);
      int rows;
      int cols;
      int total;
      bit is_last;
      rows = dim_in_use(cfg_rows);
      cols = dim_in_use(cfg_cols);
      total = rows * cols;
      beat = '0;
      has_beat = 1'b0;
      if (func == zzr_pkg::FUNC_LOAD) begin
         // A load past the end of the matrix starts a new one.
         if (fill_count >= total) fill_count = 0;
         if (fill_count == 0) restart_scan();
         if (fill_count < STORE_SIZE) elem_mem[fill_count] = value;
         fill_count++;
         return;
      end
      has_beat = 1'b1;
      is_last = (scan_index + 1 >= total);
      beat.row = cur_row[zzr_pkg::ROW_OUT_W-1:0];
      beat.col = cur_col[zzr_pkg::COL_OUT_W-1:0];
      beat.last = is_last;
      if (fill_count < total) begin
         // The cursor holds its place while the matrix is incomplete.
         beat.status = 1'b1;
         return;
      end
      beat.data = elem_mem[cur_row * cols + cur_col];
      if (is_last) begin
         restart_scan();
      end else begin
         if (cur_up) begin
            if (cur_col + 1 >= cols) begin
               cur_row++;
               cur_up = 1'b0;
            end else if (cur_row == 0) begin
               cur_col++;
               cur_up = 1'b0;
            end else begin
               cur_row--;
               cur_col++;
            end
         end else begin
            if (cur_row + 1 >= rows) begin
               cur_col++;
               cur_up = 1'b1;
            end else if (cur_col == 0) begin
               cur_row++;
               cur_up = 1'b1;
            end else begin
               cur_row++;
               cur_col--;
            end
         end
         scan_index++;
      end
   endtask

   // Responses are checked before the request of the same edge is modeled;
   // a response never belongs to a request taken at the same edge.
   always @(posedge clock) begin
      bit has_beat;
      zigzag_beat_type beat;
      zigzag_beat_type want;
      zigzag_beat_type got;
      if (reset) begin
         fill_count = 0;
         cfg_rows = zzr_pkg::CSR_DATA_W'(zzr_pkg::RESET_DIM);
         cfg_cols = zzr_pkg::CSR_DATA_W'(zzr_pkg::RESET_DIM);
         restart_scan();
         pending_beats.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_data, rsp_row, rsp_col, rsp_last, rsp_status};
            if (pending_beats.size() == 0) begin
               $error("response with no request outstanding: data %0d row %0d col %0d",
                      got.data, got.row, got.col);
               error_count++;
            end else begin
               want = pending_beats.pop_front();
               if (got.data !== want.data) begin
                  $error("data: expected %0d, got %0d", want.data, got.data);
                  error_count++;
               end
               if (got.row !== want.row) begin
                  $error("row: expected %0d, got %0d", want.row, got.row);
                  error_count++;
               end
               if (got.col !== want.col) begin
                  $error("col: expected %0d, got %0d", want.col, got.col);
                  error_count++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, got.last);
                  error_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  error_count++;
               end
            end
         end
         if (csr_wr_en) begin
            if (csr_index == zzr_pkg::CSR_NUM_ROWS) cfg_rows = csr_wdata;
            else cfg_cols = csr_wdata;
            fill_count = 0;
            restart_scan();
         end
         if (req_valid && !req_stall) begin
            predict_request(req_func, req_value, has_beat, beat);
            if (has_beat) pending_beats.push_back(pin_valid ? pin_beat : beat);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Response side: random stall bursts, plus one long hold-off on request.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 5)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_request(input logic func,
                               input logic signed [zzr_pkg::DATA_IN_W-1:0] value,
                               input bit pinned, input zigzag_beat_type want);
      int gap;
      // The last stretch of the run goes without idle cycles on either side.
      if (ITEM_TARGET - items_sent < TAIL_ITEMS) idle_pct = 0;
      gap = (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_func <= func;
      req_value <= value;
      pin_valid = pinned;
      pin_beat = want;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Drops the request line and waits until every read has been answered,
   // then idles so that a load still settling in the store is written.
   task automatic drain_requests();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_geometry(input logic [zzr_pkg::CSR_DATA_W-1:0] rows,
                                 input logic [zzr_pkg::CSR_DATA_W-1:0] cols);
      drain_requests();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= zzr_pkg::CSR_NUM_ROWS;
      csr_wdata <= rows;
      @(negedge clock);
      csr_index <= zzr_pkg::CSR_NUM_COLS;
      csr_wdata <= cols;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int seg_no;
      int total;
      int early;
      int count;
      logic [zzr_pkg::CSR_DATA_W-1:0] gr;
      logic [zzr_pkg::CSR_DATA_W-1:0] gc;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = zzr_pkg::FUNC_LOAD;
      req_value = '0;
      csr_wr_en = 1'b0;
      csr_index = zzr_pkg::CSR_NUM_ROWS;
      csr_wdata = '0;
      seg_no = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idle_pct = 15;
      for (int i = 0; i < DIR_LEN; i++) begin
         case (dir_table[i].kind)
            STEP_GEOM: begin
               write_geometry(dir_table[i].rows, dir_table[i].cols);
            end
            STEP_LOAD: begin
               send_request(zzr_pkg::FUNC_LOAD, dir_table[i].value, 1'b0, '0);
            end
            default: begin
               send_request(zzr_pkg::FUNC_READ, dir_table[i].value, dir_table[i].pinned,
                            dir_table[i].want);
            end
         endcase
      end

      while (items_sent < ITEM_TARGET) begin
         seg_no++;
         case (seg_no)
            1: begin
               gr = 5'd31;
               gc = 5'd31;
            end
            2: begin
               gr = 5'd1;
               gc = 5'd16;
            end
            3: begin
               gr = 5'd16;
               gc = 5'd1;
            end
            4: begin
               gr = 5'd17;
               gc = 5'd0;
            end
            6: begin
               gr = 5'd4;
               gc = 5'd4;
            end
            default: begin
               // Large shapes only while enough items remain to keep the
               // total near its target.
               if ($urandom_range(0, 11) == 0 && ITEM_TARGET - items_sent > 800) begin
                  gr = zzr_pkg::CSR_DATA_W'($urandom_range(0, 31));
                  gc = zzr_pkg::CSR_DATA_W'($urandom_range(0, 31));
               end else begin
                  gr = zzr_pkg::CSR_DATA_W'($urandom_range(1, 6));
                  gc = zzr_pkg::CSR_DATA_W'($urandom_range(1, 6));
               end
            end
         endcase
         write_geometry(gr, gc);
         total = dim_in_use(gr) * dim_in_use(gc);

         if (ITEM_TARGET - items_sent < TAIL_ITEMS) begin
            idle_pct = 0;
         end else begin
            case ($urandom_range(0, 3))
               0: idle_pct = 0;
               1: idle_pct = 8;
               2: idle_pct = 25;
               default: idle_pct = 50;
            endcase
         end

         if (seg_no == 6 || $urandom_range(0, 9) < 8) begin
            early = ($urandom_range(0, 3) == 0) ? $urandom_range(0, total - 1) : -1;
            for (int i = 0; i < total; i++) begin
               if (i == early) send_request(zzr_pkg::FUNC_READ, $urandom, 1'b0, '0);
               send_request(zzr_pkg::FUNC_LOAD, $urandom, 1'b0, '0);
            end
            // The long hold-off starts just before the reads of a full pass,
            // so reads back up behind the held response and the block stalls
            // requests.
            if (seg_no == 6) hold_off_req = 1'b1;
            count = total * $urandom_range(1, 2) + $urandom_range(0, 2);
            for (int i = 0; i < count; i++) begin
               send_request(zzr_pkg::FUNC_READ, $urandom, 1'b0, '0);
            end
         end else begin
            count = $urandom_range(total, (3 * total > 200) ? 200 : 3 * total);
            for (int i = 0; i < count; i++) begin
               send_request(($urandom_range(0, 9) < 6) ? zzr_pkg::FUNC_LOAD
                                                       : zzr_pkg::FUNC_READ,
                            $urandom, 1'b0, '0);
            end
         end
      end

      drain_requests();
      repeat (6) @(posedge clock);
      if (pending_beats.size() != 0) begin
         $error("%0d read responses never arrived", pending_beats.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/zzr_pkg.sv
rtl/zzr_ctrl.sv
rtl/zzr_datapath.sv
rtl/zigzag_matrix_reorder_unit.sv
bench/zigzag_matrix_reorder_unit_tb.sv
